>>> hdl/rdbc_pkg.sv
// Shared types, constants and decode functions for the RNA dot-bracket checker.
package rdbc_pkg;

  // Stack and strand sizing
  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int CNT_W       = 11;
  localparam int POS_W       = 11;
  localparam logic [POS_W-1:0] POS_SAT = 11'd2047;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // ASCII codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LRND  = 8'h28;
  localparam logic [7:0] CH_RRND  = 8'h29;
  localparam logic [7:0] CH_LSQ   = 8'h5B;
  localparam logic [7:0] CH_RSQ   = 8'h5D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Base codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_U = 2'd3;

  typedef enum logic [1:0] {
    SK_DOT,
    SK_OPEN,
    SK_CLOSE,
    SK_BAD
  } sym_kind_t;

  // One item as it passes from front to back
  typedef struct packed {
    logic [1:0]        base_code;
    logic              base_ok;
    logic [7:0]        tree_symbol;
    logic              pair_valid;
    logic [1:0]        open_base;
    logic [ADDR_W-1:0] open_position;
    logic [ADDR_W-1:0] close_position;
    logic              last;
    logic              front_err;
    logic              cnt_zero;
    logic              pk;
  } q_entry_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]        base_code;
    logic              base_ok;
    logic [7:0]        tree_symbol;
    logic              pair_valid;
    logic [ADDR_W-1:0] open_position;
    logic [ADDR_W-1:0] close_position;
    logic              done_res;
    logic              accepted;
    logic              uses_pseudoknot;
  } res_t;

  // {ok, code}; code is A when the byte is no nucleotide
  function automatic logic [2:0] decode_base(logic [7:0] b);
    logic [7:0] u;
    logic [2:0] r;
    u = b;
    if (b >= CH_LOW_A && b <= CH_LOW_Z) u = b - CASE_GAP;
    case (u) inside
      CH_A:       r = {1'b1, BASE_A};
      CH_C:       r = {1'b1, BASE_C};
      CH_G:       r = {1'b1, BASE_G};
      CH_T, CH_U: r = {1'b1, BASE_U};
      default:    r = {1'b0, BASE_A};
    endcase
    return r;
  endfunction

  // Watson-Crick and wobble pairs
  function automatic logic bases_pair(logic [1:0] l, logic [1:0] r);
    logic ok;
    case ({l, r}) inside
      {BASE_A, BASE_U}, {BASE_U, BASE_A},
      {BASE_C, BASE_G}, {BASE_G, BASE_C},
      {BASE_G, BASE_U}, {BASE_U, BASE_G}: ok = 1'b1;
      default:                            ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> hdl/rdbc_if.sv
// Valid/ready channel interfaces for strand positions and results.
interface rdbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] seq_symbol;
  logic [7:0] structure_symbol;
  logic       last;

  modport source (output valid, output seq_symbol, output structure_symbol, output last,
                  input ready);
  modport sink   (input valid, input seq_symbol, input structure_symbol, input last,
                  output ready);
endinterface

interface rdbc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] base_code;
  logic       base_ok;
  logic [7:0] tree_symbol;
  logic       pair_valid;
  logic [9:0] open_position;
  logic [9:0] close_position;
  logic       done_res;
  logic       accepted;
  logic       uses_pseudoknot;

  modport source (output valid, output base_code, output base_ok, output tree_symbol,
                  output pair_valid, output open_position, output close_position,
                  output done_res, output accepted, output uses_pseudoknot,
                  input ready);
  modport sink   (input valid, input base_code, input base_ok, input tree_symbol,
                  input pair_valid, input open_position, input close_position,
                  input done_res, input accepted, input uses_pseudoknot,
                  output ready);
endinterface

>>> hdl/rna_dot_bracket_checker.sv
// Top level of the RNA dot-bracket checker: front end, queue and back end.
//
// in_ch carries one strand position per transaction: a sequence byte, a
// structure byte and last, which marks the final position. out_ch returns
// exactly one result per position, in order: the normalised base, the tree
// view of the structure byte, the pair of positions when a closer pops its
// opener, and on the last position the accept verdict and pseudoknot flag.
// A new position is taken every cycle while the queue and read stage have
// room; its result passes the stack read stage, queue and output register.
// The front end keeps both bracket stacks in 1024-entry memories, one push
// or one pop per transaction, with the popped opener read in the next cycle.
// Pairing is checked in the back end when the closer reaches it.
// When the receiver stalls, the output register holds and the four-entry
// queue fills; in_ch.ready drops once the queue and the read stage leave no
// room, and rises as soon as the receiver takes a result.
// Reset clears the stack counts, position, flags, queue and output valid;
// stack memories need no clearing, since only entries below the count are
// ever read. After a last position the strand state starts afresh.
module rna_dot_bracket_checker import rdbc_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  rdbc_in_if.sink     in_ch,
  rdbc_out_if.source  out_ch
);

  logic              q_wr;
  q_entry_t          q_wdata;
  logic              q_rd;
  logic              q_valid;
  q_entry_t          q_rdata;
  logic [QCNT_W-1:0] q_level;

  rdbc_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_level (q_level),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  rdbc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .rd     (q_rd),
    .rvalid (q_valid),
    .rdata  (q_rdata),
    .level  (q_level)
  );

  rdbc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_rdata (q_rdata),
    .q_pop   (q_rd),
    .out_ch  (out_ch)
  );

endmodule

>>> hdl/rdbc_front.sv
// Front end: decodes each position, runs both bracket stacks and reads the popped opener.
module rdbc_front import rdbc_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  rdbc_in_if.sink           in_ch,
  input  logic [QCNT_W-1:0] q_level,
  output logic              q_wr,
  output q_entry_t          q_wdata
);

  // Stack memories: {base, position}
  logic [ADDR_W+1:0] rnd_mem [STACK_DEPTH];
  logic [ADDR_W+1:0] sq_mem  [STACK_DEPTH];
  logic [ADDR_W+1:0] rnd_rd_r, sq_rd_r;

  logic [CNT_W-1:0] rnd_cnt_r, rnd_cnt_nxt;
  logic [CNT_W-1:0] sq_cnt_r, sq_cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             err_r, err_nxt;
  logic             sq_seen_r, sq_seen_nxt;

  // Item waiting for its read data
  logic             s1_valid_r;
  logic             s1_sq_r;
  q_entry_t         s1_r, s1_nxt;

  logic [1:0]       base;
  logic             base_ok;
  sym_kind_t        kind;
  logic             is_sq;
  logic             in_range;
  logic [CNT_W-1:0] cnt_sel, cnt_new;
  logic             push_ok, pop_ok, err_now;
  logic [CNT_W-1:0] rnd_after, sq_after;
  logic             accept;
  logic [QCNT_W:0]  credit;

  // Credit: queue entries plus the item in flight
  always_comb begin
    credit      = {1'b0, q_level} + {{QCNT_W{1'b0}}, s1_valid_r};
    in_ch.ready = (credit < (QCNT_W+1)'(QDEPTH));
  end

  assign accept = in_ch.valid && in_ch.ready;

  // Classify the transaction
  always_comb begin
    {base_ok, base} = decode_base(in_ch.seq_symbol);
    is_sq = 1'b0;
    unique case (in_ch.structure_symbol)
      CH_DOT:  kind = SK_DOT;
      CH_LRND: kind = SK_OPEN;
      CH_RRND: kind = SK_CLOSE;
      CH_LSQ: begin
        kind  = SK_OPEN;
        is_sq = 1'b1;
      end
      CH_RSQ: begin
        kind  = SK_CLOSE;
        is_sq = 1'b1;
      end
      default: kind = SK_BAD;
    endcase

    in_range = !pos_r[POS_W-1] && (int'(pos_r) < MAX_LEN);
    cnt_sel  = is_sq ? sq_cnt_r : rnd_cnt_r;
    push_ok  = in_range && (kind == SK_OPEN) && !cnt_sel[CNT_W-1];
    pop_ok   = in_range && (kind == SK_CLOSE) && (cnt_sel != '0);
    err_now  = !base_ok || !in_range || (kind == SK_BAD) ||
               (in_range && (kind == SK_OPEN) && cnt_sel[CNT_W-1]) ||
               (in_range && (kind == SK_CLOSE) && (cnt_sel == '0));

    if (push_ok)     cnt_new = cnt_sel + CNT_W'(1);
    else if (pop_ok) cnt_new = cnt_sel - CNT_W'(1);
    else             cnt_new = cnt_sel;

    rnd_after = (!is_sq && (push_ok || pop_ok)) ? cnt_new : rnd_cnt_r;
    sq_after  = ( is_sq && (push_ok || pop_ok)) ? cnt_new : sq_cnt_r;
    sq_seen_nxt = sq_seen_r || is_sq;
    err_nxt     = err_r || err_now;

    s1_nxt                = '0;
    s1_nxt.base_code      = base;
    s1_nxt.base_ok        = base_ok;
    s1_nxt.tree_symbol    = is_sq ? CH_DOT : in_ch.structure_symbol;
    s1_nxt.pair_valid     = pop_ok;
    s1_nxt.close_position = pop_ok ? pos_r[ADDR_W-1:0] : '0;
    s1_nxt.last           = in_ch.last;
    s1_nxt.front_err      = err_nxt;
    s1_nxt.cnt_zero       = (rnd_after == '0) && (sq_after == '0);
    s1_nxt.pk             = sq_seen_nxt;

    rnd_cnt_nxt = rnd_cnt_r;
    sq_cnt_nxt  = sq_cnt_r;
    pos_nxt     = pos_r;
    if (accept) begin
      if (in_ch.last) begin
        rnd_cnt_nxt = '0;
        sq_cnt_nxt  = '0;
        pos_nxt     = '0;
      end else begin
        rnd_cnt_nxt = rnd_after;
        sq_cnt_nxt  = sq_after;
        pos_nxt     = (pos_r == POS_SAT) ? pos_r : pos_r + POS_W'(1);
      end
    end
  end

  // Strand state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_cnt_r  <= '0;
      sq_cnt_r   <= '0;
      pos_r      <= '0;
      err_r      <= 1'b0;
      sq_seen_r  <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      rnd_cnt_r  <= rnd_cnt_nxt;
      sq_cnt_r   <= sq_cnt_nxt;
      pos_r      <= pos_nxt;
      s1_valid_r <= accept;
      if (accept) begin
        err_r     <= in_ch.last ? 1'b0 : err_nxt;
        sq_seen_r <= in_ch.last ? 1'b0 : sq_seen_nxt;
      end
    end
  end

  // Payload of the item in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r    <= s1_nxt;
      s1_sq_r <= is_sq;
    end
  end

  // Round stack: one push or one pop per transaction
  always_ff @(posedge clk) begin
    if (accept && push_ok && !is_sq)
      rnd_mem[cnt_sel[ADDR_W-1:0]] <= {base, pos_r[ADDR_W-1:0]};
    if (accept && pop_ok && !is_sq)
      rnd_rd_r <= rnd_mem[cnt_new[ADDR_W-1:0]];
  end

  // Square stack
  always_ff @(posedge clk) begin
    if (accept && push_ok && is_sq)
      sq_mem[cnt_sel[ADDR_W-1:0]] <= {base, pos_r[ADDR_W-1:0]};
    if (accept && pop_ok && is_sq)
      sq_rd_r <= sq_mem[cnt_new[ADDR_W-1:0]];
  end

  // Merge read data and hand the item to the queue
  always_comb begin
    logic [ADDR_W+1:0] rd;
    rd      = s1_sq_r ? sq_rd_r : rnd_rd_r;
    q_wr    = s1_valid_r;
    q_wdata = s1_r;
    if (s1_r.pair_valid) begin
      q_wdata.open_base     = rd[ADDR_W+1:ADDR_W];
      q_wdata.open_position = rd[ADDR_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    credit <= (QCNT_W+1)'(QDEPTH))
    else $error("queue credit overrun");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (rnd_cnt_r <= CNT_W'(STACK_DEPTH)) && (sq_cnt_r <= CNT_W'(STACK_DEPTH)))
    else $error("stack count beyond depth");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last) |=> (pos_r == '0 && rnd_cnt_r == '0 && sq_cnt_r == '0))
    else $error("strand state not cleared after last");
`endif

endmodule

>>> hdl/rdbc_queue.sv
// Short FIFO that decouples the stack front end from the result back end.
module rdbc_queue import rdbc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  q_entry_t          wdata,
  input  logic              rd,
  output logic              rvalid,
  output q_entry_t          rdata,
  output logic [QCNT_W-1:0] level
);

  q_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign rvalid = (cnt_r != '0);
  assign rdata  = mem[rd_ptr_r];
  assign level  = cnt_r;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (rd) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr_r] <= wdata;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> (cnt_r < QCNT_W'(QDEPTH)) || rd)
    else $error("queue write when full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> rvalid)
    else $error("queue read when empty");
`endif

endmodule

>>> hdl/rdbc_back.sv
// Back end: checks base pairing at the close and forms the registered result.
module rdbc_back import rdbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  q_entry_t q_rdata,
  output logic     q_pop,
  rdbc_out_if.source out_ch
);

  res_t res_r, res_nxt;
  logic out_valid_r;
  logic mispair_r;
  logic mispair_now;
  logic load;

  // Pair check and verdict
  always_comb begin
    mispair_now = q_rdata.pair_valid && !bases_pair(q_rdata.open_base, q_rdata.base_code);
    load        = q_valid && (!out_valid_r || out_ch.ready);
    q_pop       = load;

    res_nxt.base_code       = q_rdata.base_code;
    res_nxt.base_ok         = q_rdata.base_ok;
    res_nxt.tree_symbol     = q_rdata.tree_symbol;
    res_nxt.pair_valid      = q_rdata.pair_valid;
    res_nxt.open_position   = q_rdata.open_position;
    res_nxt.close_position  = q_rdata.close_position;
    res_nxt.done_res        = q_rdata.last;
    res_nxt.accepted        = q_rdata.last && !q_rdata.front_err && !mispair_r &&
                              !mispair_now && q_rdata.cnt_zero;
    res_nxt.uses_pseudoknot = q_rdata.last && q_rdata.pk;
  end

  // Output register and strand mispair flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mispair_r   <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        mispair_r   <= q_rdata.last ? 1'b0 : (mispair_r || mispair_now);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.base_code       = res_r.base_code;
  assign out_ch.base_ok         = res_r.base_ok;
  assign out_ch.tree_symbol     = res_r.tree_symbol;
  assign out_ch.pair_valid      = res_r.pair_valid;
  assign out_ch.open_position   = res_r.open_position;
  assign out_ch.close_position  = res_r.close_position;
  assign out_ch.done_res        = res_r.done_res;
  assign out_ch.accepted        = res_r.accepted;
  assign out_ch.uses_pseudoknot = res_r.uses_pseudoknot;

`ifndef NO_ASSERTIONS
  a_no_pair_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.pair_valid) |-> (res_r.open_position == '0 &&
                                           res_r.close_position == '0))
    else $error("pair positions set without a pair");
  a_verdict_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.done_res) |-> (!res_r.accepted && !res_r.uses_pseudoknot))
    else $error("strand verdict outside the last result");
`endif

endmodule
